@@ src/drcm_pkg.sv @@
package drcm_pkg;

  localparam int MV_W       = 13;
  localparam int TIME_W     = 32;
  localparam int LIMIT_A_W  = 12;
  localparam int SURGE_T_W  = 16;
  localparam int FILT_W     = 14;
  localparam int CURRENT_W  = 23;
  localparam int LIMIT_MA_W = 22;
  localparam int CAUSE_W    = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_COARSE_ZERO = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FINE_ZERO   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONT_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SURGE_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SURGE_TIME  = 3'd4;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_ABS   = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SURGE = 2'd2;

  localparam logic signed [9:0] COARSE_MA_PER_MV = 10'sd400;
  localparam logic signed [6:0] FINE_MA_PER_MV   = 7'sd58;
  localparam logic [9:0]        MA_PER_A         = 10'd1000;
  localparam int                FINE_RANGE_MA    = 75000;

  // largest coarse filter magnitude whose current stays inside the fine range
  localparam int FINE_RANGE_FILT = (FINE_RANGE_MA - 1) / 400;
  localparam logic signed [FILT_W-1:0] FINE_FILT_HI = FILT_W'(FINE_RANGE_FILT);
  localparam logic signed [FILT_W-1:0] FINE_FILT_LO = FILT_W'(-FINE_RANGE_FILT);

endpackage

@@ src/drcm_if.sv @@
interface drcm_sample_if;
  logic                           valid;
  logic                           ready;
  logic [drcm_pkg::MV_W-1:0]      coarse_mv;
  logic [drcm_pkg::MV_W-1:0]      fine_mv;
  logic [drcm_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, coarse_mv, fine_mv, now_ms, input ready);
  modport sink   (input valid, coarse_mv, fine_mv, now_ms, output ready);
endinterface

interface drcm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [drcm_pkg::CURRENT_W-1:0] current_ma;
  logic                                 fault;
  logic [drcm_pkg::CAUSE_W-1:0]         fault_cause;
  logic                                 surging;

  modport source (output valid, current_ma, fault, fault_cause, surging, input ready);
  modport sink   (input valid, current_ma, fault, fault_cause, surging, output ready);
endinterface

@@ src/dual_range_current_monitor_top.sv @@
// channel   direction  contents
// samples   in         coarse_mv, fine_mv, now_ms
// results   out        current_ma, fault, fault_cause, surging
// cfg_*     in         write enable, register index, write data
//
// one sample per cycle sustained while results.ready stays high; a sample passes
// through the input register, then the result register, all arithmetic in between
// filters and surge state update as a sample moves into the result register
// a held result stalls the input register only when that register is full
// synchronous active-high reset clears control, filters, surge state and config
module dual_range_current_monitor_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [drcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [drcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  drcm_sample_if.sink                         samples,
  drcm_result_if.source                       results
);

  // configuration
  logic [drcm_pkg::MV_W-1:0]       coarse_zero;
  logic [drcm_pkg::MV_W-1:0]       fine_zero;
  logic [drcm_pkg::LIMIT_MA_W-1:0] cont_ma;
  logic [drcm_pkg::LIMIT_MA_W-1:0] surge_ma;
  logic [drcm_pkg::SURGE_T_W-1:0]  surge_time;

  // input register
  logic                          sample_valid;
  logic [drcm_pkg::MV_W-1:0]     sample_coarse;
  logic [drcm_pkg::MV_W-1:0]     sample_fine;
  logic [drcm_pkg::TIME_W-1:0]   sample_now;

  // state
  logic signed [drcm_pkg::FILT_W-1:0] coarse_filter;
  logic signed [drcm_pkg::FILT_W-1:0] fine_filter;
  logic                               surge_active;
  logic [drcm_pkg::TIME_W-1:0]        surge_onset;

  // result register
  logic                                  result_valid;
  logic signed [drcm_pkg::CURRENT_W-1:0] result_ma;
  logic [drcm_pkg::CAUSE_W-1:0]          result_cause;
  logic                                  result_surging;

  logic advance;
  logic step;

  logic signed [drcm_pkg::FILT_W-1:0]    coarse_delta;
  logic signed [drcm_pkg::FILT_W-1:0]    fine_delta;
  logic signed [drcm_pkg::FILT_W:0]      coarse_sum;
  logic signed [drcm_pkg::FILT_W:0]      fine_sum;
  logic signed [drcm_pkg::FILT_W-1:0]    coarse_filter_next;
  logic signed [drcm_pkg::FILT_W-1:0]    fine_filter_next;
  logic signed [drcm_pkg::CURRENT_W-1:0] coarse_ma;
  logic signed [drcm_pkg::CURRENT_W-1:0] fine_ma;
  logic signed [drcm_pkg::CURRENT_W-1:0] ma;
  logic                                  use_fine;
  logic                                  above_cont;
  logic                                  above_surge;
  logic                                  below_surge;
  logic                                  in_window;
  logic [drcm_pkg::TIME_W-1:0]           surge_onset_next;
  logic [drcm_pkg::TIME_W-1:0]           elapsed;
  logic                                  timed_out;
  logic [drcm_pkg::CAUSE_W-1:0]          cause;

  assign advance       = !result_valid || results.ready;
  assign step          = sample_valid && advance;
  assign samples.ready = !sample_valid || advance;

  // offset removal and half-sum filter, arithmetic shift gives floor
  assign coarse_delta = $signed({1'b0, sample_coarse}) - $signed({1'b0, coarse_zero});
  assign fine_delta   = $signed({1'b0, sample_fine}) - $signed({1'b0, fine_zero});
  assign coarse_sum   = {coarse_filter[drcm_pkg::FILT_W-1], coarse_filter}
                        + {coarse_delta[drcm_pkg::FILT_W-1], coarse_delta};
  assign fine_sum     = {fine_filter[drcm_pkg::FILT_W-1], fine_filter}
                        + {fine_delta[drcm_pkg::FILT_W-1], fine_delta};
  assign coarse_filter_next = coarse_sum[drcm_pkg::FILT_W:1];
  assign fine_filter_next   = fine_sum[drcm_pkg::FILT_W:1];

  assign coarse_ma = drcm_pkg::CURRENT_W'(coarse_filter_next)
                     * drcm_pkg::CURRENT_W'(drcm_pkg::COARSE_MA_PER_MV);
  assign fine_ma   = drcm_pkg::CURRENT_W'(fine_filter_next)
                     * drcm_pkg::CURRENT_W'(drcm_pkg::FINE_MA_PER_MV);

  // range choice taken on the filter value itself, ahead of the multiply
  assign use_fine = (coarse_filter_next <= drcm_pkg::FINE_FILT_HI)
                    && (coarse_filter_next >= drcm_pkg::FINE_FILT_LO);
  assign ma       = use_fine ? fine_ma : coarse_ma;

  // limits are non-negative, so a negative current never exceeds them
  assign above_cont  = !ma[drcm_pkg::CURRENT_W-1]
                       && (ma[drcm_pkg::LIMIT_MA_W-1:0] > cont_ma);
  assign above_surge = !ma[drcm_pkg::CURRENT_W-1]
                       && (ma[drcm_pkg::LIMIT_MA_W-1:0] > surge_ma);
  assign below_surge = ma[drcm_pkg::CURRENT_W-1]
                       || (ma[drcm_pkg::LIMIT_MA_W-1:0] < surge_ma);
  assign in_window   = above_cont && below_surge;

  assign surge_onset_next = surge_active ? surge_onset : sample_now;
  assign elapsed          = sample_now - surge_onset_next;
  assign timed_out        = elapsed >= {{(drcm_pkg::TIME_W - drcm_pkg::SURGE_T_W){1'b0}},
                                         surge_time};

  always_comb begin
    priority if (in_window && timed_out) begin
      cause = drcm_pkg::CAUSE_SURGE;
    end else if (above_surge) begin
      cause = drcm_pkg::CAUSE_ABS;
    end else begin
      cause = drcm_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_zero <= '0;
      fine_zero   <= '0;
      cont_ma     <= '0;
      surge_ma    <= '0;
      surge_time  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        drcm_pkg::REG_COARSE_ZERO: coarse_zero <= cfg_data[drcm_pkg::MV_W-1:0];
        drcm_pkg::REG_FINE_ZERO:   fine_zero   <= cfg_data[drcm_pkg::MV_W-1:0];
        drcm_pkg::REG_CONT_LIMIT:  cont_ma     <=
          drcm_pkg::LIMIT_MA_W'(cfg_data[drcm_pkg::LIMIT_A_W-1:0])
          * drcm_pkg::LIMIT_MA_W'(drcm_pkg::MA_PER_A);
        drcm_pkg::REG_SURGE_LIMIT: surge_ma    <=
          drcm_pkg::LIMIT_MA_W'(cfg_data[drcm_pkg::LIMIT_A_W-1:0])
          * drcm_pkg::LIMIT_MA_W'(drcm_pkg::MA_PER_A);
        drcm_pkg::REG_SURGE_TIME:  surge_time  <= cfg_data[drcm_pkg::SURGE_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (samples.ready) begin
      sample_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sample_coarse <= samples.coarse_mv;
      sample_fine   <= samples.fine_mv;
      sample_now    <= samples.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      coarse_filter <= '0;
      fine_filter   <= '0;
      surge_active  <= 1'b0;
      surge_onset   <= '0;
    end else begin
      if (advance) begin
        result_valid <= sample_valid;
      end
      if (step) begin
        coarse_filter <= coarse_filter_next;
        fine_filter   <= fine_filter_next;
        surge_active  <= in_window;
        if (in_window) begin
          surge_onset <= surge_onset_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_ma      <= ma;
      result_cause   <= cause;
      result_surging <= in_window;
    end
  end

  assign results.valid       = result_valid;
  assign results.current_ma  = result_ma;
  assign results.fault_cause = result_cause;
  assign results.fault       = result_cause != drcm_pkg::CAUSE_NONE;
  assign results.surging     = result_surging;

endmodule

@@ tb/sv/drcm_current_checker.sv @@
module drcm_current_checker
  import drcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  drcm_sample_if                 samples,
  drcm_result_if                 results,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic signed [CURRENT_W-1:0] current_ma;
    logic                        fault;
    logic [CAUSE_W-1:0]          fault_cause;
    logic                        surging;
  } reading_t;

  // shadow copy of the configuration registers
  logic [MV_W-1:0]      coarse_zero;
  logic [MV_W-1:0]      fine_zero;
  logic [LIMIT_A_W-1:0] cont_limit;
  logic [LIMIT_A_W-1:0] surge_limit;
  logic [SURGE_T_W-1:0] surge_time;

  // filter and surge state as the block should hold it
  int                coarse_filt;
  int                fine_filt;
  logic              surge_on;
  logic [TIME_W-1:0] surge_onset;

  reading_t readings_due[$];
  reading_t due;
  int       mismatches;

  function automatic reading_t next_reading(input logic [MV_W-1:0] coarse_mv,
                                            input logic [MV_W-1:0] fine_mv,
                                            input logic [TIME_W-1:0] now_ms);
    int                 ma;
    int                 cont_ma;
    int                 surge_ma;
    logic [TIME_W-1:0]  elapsed;
    logic [CAUSE_W-1:0] cause;
    reading_t           r;
    // arithmetic shift of a signed sum rounds towards minus infinity
    coarse_filt = (coarse_filt + int'(coarse_mv) - int'(coarse_zero)) >>> 1;
    fine_filt   = (fine_filt + int'(fine_mv) - int'(fine_zero)) >>> 1;
    ma = coarse_filt * int'(COARSE_MA_PER_MV);
    if (ma < FINE_RANGE_MA && ma > -FINE_RANGE_MA) begin
      ma = fine_filt * int'(FINE_MA_PER_MV);
    end
    cont_ma  = int'(cont_limit) * int'(MA_PER_A);
    surge_ma = int'(surge_limit) * int'(MA_PER_A);
    cause = CAUSE_NONE;
    if (ma > surge_ma) begin
      cause = CAUSE_ABS;
    end
    if (ma > cont_ma && ma < surge_ma) begin
      if (!surge_on) begin
        surge_onset = now_ms;
        surge_on    = 1'b1;
      end
      elapsed = now_ms - surge_onset;
      if (elapsed >= TIME_W'(surge_time)) begin
        cause = CAUSE_SURGE;
      end
    end else begin
      surge_on = 1'b0;
    end
    r.current_ma  = ma[CURRENT_W-1:0];
    r.fault       = (cause != CAUSE_NONE);
    r.fault_cause = cause;
    r.surging     = surge_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coarse_zero  = '0;
      fine_zero    = '0;
      cont_limit   = '0;
      surge_limit  = '0;
      surge_time   = '0;
      coarse_filt  = 0;
      fine_filt    = 0;
      surge_on     = 1'b0;
      surge_onset  = '0;
      mismatches   = 0;
      readings_due.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COARSE_ZERO: coarse_zero = cfg_data[MV_W-1:0];
          REG_FINE_ZERO:   fine_zero   = cfg_data[MV_W-1:0];
          REG_CONT_LIMIT:  cont_limit  = cfg_data[LIMIT_A_W-1:0];
          REG_SURGE_LIMIT: surge_limit = cfg_data[LIMIT_A_W-1:0];
          REG_SURGE_TIME:  surge_time  = cfg_data[SURGE_T_W-1:0];
          default: ;
        endcase
      end
      // results first: a sample taken at this edge cannot be the one leaving
      if (results.valid && results.ready) begin
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing outstanding: current %0d fault %0d cause %0d",
                     $realtime, results.current_ma, results.fault, results.fault_cause);
          end
        end else begin
          due = readings_due.pop_front();
          if (results.current_ma !== due.current_ma || results.fault !== due.fault ||
              results.fault_cause !== due.fault_cause || results.surging !== due.surging) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected current %0d fault %0d cause %0d surging %0d",
                       $realtime, due.current_ma, due.fault, due.fault_cause, due.surging);
              $display("%0t:           actual   current %0d fault %0d cause %0d surging %0d",
                       $realtime, results.current_ma, results.fault, results.fault_cause,
                       results.surging);
            end
          end
        end
      end
      if (samples.valid && samples.ready) begin
        readings_due.push_back(next_reading(samples.coarse_mv, samples.fine_mv,
                                            samples.now_ms));
      end
      pending    <= readings_due.size();
      fail_count <= mismatches;
    end
  end

endmodule

@@ tb/sv/dual_range_current_monitor_top_tb.sv @@
module dual_range_current_monitor_top_tb;
  import drcm_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  bit                     gaps_on = 1'b1;
  int                     idle_cycles = 0;
  logic [TIME_W-1:0]      clock_ms = '0;

  drcm_sample_if samples();
  drcm_result_if results();

  dual_range_current_monitor_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results)
  );

  drcm_current_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .results    (results),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [MV_W-1:0] to_mv(input int v);
    if (v < 0) return '0;
    if (v > 8191) return 13'h1FFF;
    return v[MV_W-1:0];
  endfunction

  task automatic put_sample(input logic [MV_W-1:0] coarse_mv,
                            input logic [MV_W-1:0] fine_mv,
                            input logic [TIME_W-1:0] now_ms);
    while (gaps_on && $urandom_range(99) < 16) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid     <= 1'b1;
    samples.coarse_mv <= coarse_mv;
    samples.fine_mv   <= fine_mv;
    samples.now_ms    <= now_ms;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_step(input logic [CFG_INDEX_W-1:0] idx, input int value, input int width);
    logic [CFG_DATA_W-1:0] d;
    // junk above the register width must be dropped by the block
    d = CFG_DATA_W'($urandom);
    for (int b = 0; b < width; b++) d[b] = value[b];
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic write_config(input int cz, input int fz, input int cl, input int sl,
                              input int st);
    cfg_step(REG_COARSE_ZERO, cz, MV_W);
    cfg_step(REG_FINE_ZERO, fz, MV_W);
    cfg_step(REG_CONT_LIMIT, cl, LIMIT_A_W);
    cfg_step(REG_SURGE_LIMIT, sl, LIMIT_A_W);
    cfg_step(REG_SURGE_TIME, st, SURGE_T_W);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int  cz, fz, cl, sl, st;
    int  n, seg_len, mode, base_a, ft, c_base, f_base, step_max;
    bit  paused;
    samples.valid     <= 1'b0;
    samples.coarse_mv <= '0;
    samples.fine_mv   <= '0;
    samples.now_ms    <= '0;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_COARSE_ZERO;
    cfg_data          <= '0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: every limit zero, so the surge window is empty
    put_sample(13'h0000, 13'h0000, 32'h0000_0000);
    put_sample(13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF);
    put_sample(13'h1FFF, 13'h0000, 32'h5555_AAAA);
    put_sample(13'h0000, 13'h1FFF, 32'hAAAA_5555);
    put_sample(13'h0AAA, 13'h1555, 32'h0000_0000);

    // zero surge time, filter climbs through the window onto the surge limit
    wait_drained();
    write_config(0, 0, 100, 200, 0);
    repeat (11) begin
      clock_ms = clock_ms + 1;
      put_sample(13'd501, 13'd0, clock_ms);
    end

    // full offsets drive the current far negative
    wait_drained();
    write_config(8191, 8191, 0, 1, 0);
    put_sample(13'h0000, 13'h0000, 32'd100);
    put_sample(13'h0000, 13'h1FFF, 32'd101);
    put_sample(13'h1FFF, 13'h0000, 32'd102);

    for (int k = 0; k < 8; k++) begin
      cz = $urandom_range(0, 4096);
      fz = $urandom_range(0, 4096);
      cl = $urandom_range(0, 3000);
      sl = $urandom_range(cl + 1, 4000);
      st = $urandom_range(0, 200);
      case (k)
        0: begin
          cz = 8191; fz = 8191; cl = 4000; sl = 4000; st = 65535;
        end
        1: begin
          cz = 4096; fz = 4096; cl = 20; sl = 60; st = $urandom_range(0, 30);
        end
        2: begin
          sl = $urandom_range(0, cl);
        end
        3: begin
          st = 0;
        end
        4: begin
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
          cl = $urandom_range(0, 40);
          sl = $urandom_range(cl + 1, 74);
          st = $urandom_range(20, 400);
        end
        default: ;
      endcase
      wait_drained();
      write_config(cz, fz, cl, sl, st);
      gaps_on <= (k != 1);
      step_max = st / 4 + 2;
      n = 0;
      while (n < 80) begin
        if (k == 2 && n >= 40 && !paused) begin
          // hold the sender back until everything in flight has come out
          wait_drained();
          paused = 1'b1;
        end
        seg_len = $urandom_range(3, 20);
        mode    = $urandom_range(0, 9);
        c_base  = 0;
        f_base  = 0;
        if (mode >= 2 && mode <= 5) begin
          case ($urandom_range(0, 4))
            0: base_a = cl;
            1: base_a = sl;
            2: base_a = $urandom_range(0, 4000);
            3: base_a = -int'($urandom_range(0, 3300));
            default: base_a = 0;
          endcase
          ft = base_a * 5 / 2 + int'($urandom_range(0, 4)) - 2;
          if (base_a == 0) begin
            // straddle the edge of the fine range
            ft = ($urandom_range(0, 1) ? 187 : 188) * ($urandom_range(0, 1) ? 1 : -1);
          end
          c_base = cz + ft + int'($urandom_range(0, 1));
          f_base = $urandom_range(0, 8191);
        end else if (mode >= 6) begin
          case ($urandom_range(0, 3))
            0: base_a = cl;
            1: base_a = sl;
            2: base_a = $urandom_range(0, 80);
            default: base_a = -int'($urandom_range(0, 80));
          endcase
          c_base = cz + int'($urandom_range(0, 300)) - 150;
          f_base = fz + base_a * 1000 / 58 + int'($urandom_range(0, 4)) - 2;
        end
        for (int i = 0; i < seg_len && n < 80; i++) begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          if (mode < 2) begin
            put_sample(MV_W'($urandom_range(0, 8191)), MV_W'($urandom_range(0, 8191)),
                       $urandom);
          end else if ($urandom_range(0, 3) == 0) begin
            put_sample(to_mv(c_base + int'($urandom_range(0, 2)) - 1),
                       to_mv(f_base + int'($urandom_range(0, 2)) - 1), clock_ms);
          end else begin
            put_sample(to_mv(c_base), to_mv(f_base), clock_ms);
          end
          n++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ dual_range_current_monitor_top.f @@
src/drcm_pkg.sv
src/drcm_if.sv
src/dual_range_current_monitor_top.sv
tb/sv/drcm_current_checker.sv
tb/sv/dual_range_current_monitor_top_tb.sv
